### rtl/core/ktt_pkg.sv
// Shared types, constants and helpers for the keyword table tokenizer.
`default_nettype none
package ktt_pkg;

   localparam int NUM_TOKENS_DEF    = 4;
   localparam int MAX_TOKEN_LEN_DEF = 8;
   localparam int OFFSET_BITS_DEF   = 24;

   localparam int SLOT_COUNT   = 4;
   localparam int FIELD_W      = 24;
   localparam int POS_W        = 16;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 3;
   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_PTR_W   = 2;
   localparam int FIFO_CNT_W   = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT0   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT1   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT2   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT3   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTHS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPECIAL = 3'd7;

   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_NL      = 8'd10;
   localparam logic [7:0] CHAR_CR      = 8'd13;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [4:0] TAB_ADVANCE  = 5'd8;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       has_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] token_start;
      logic [FIELD_W-1:0] token_length;
      logic [POS_W-1:0]   token_line;
      logic [POS_W-1:0]   token_column;
      logic [7:0]         token_symbol;
      logic               last_of_run;
   } rsp_type;

   // saturating add for line / column counters
   function automatic logic [POS_W-1:0] sat_add16(input logic [POS_W-1:0] a,
                                                  input logic [4:0] b);
      logic [POS_W:0] s;
      s = {1'b0, a} + {{(POS_W-4){1'b0}}, b};
      return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

endpackage
`default_nettype wire

### rtl/core/keyword_table_tokenizer_unit.sv
// Top level of the keyword table tokenizer: window, matcher, result queue.
`default_nettype none
// Keyword table tokenizer. Text arrives one byte per req beat; bytes fill a
// lookahead window of MAX_TOKEN_LEN bytes and, once it is full, every beat
// decides one start position in the same cycle: whitespace, the first
// configured keyword slot (all slots compare in parallel), or one byte of a
// string run. Each decision yields up to two tokens (pending string run, then
// keyword), written to a 4-entry result queue that feeds rsp; req takes one
// beat per cycle while the queue has two free entries, so the sustained rate
// is one byte per cycle, bounded by one rsp beat per cycle. A beat with
// end_of_text set starts a drain: req stalls through each decision (at
// most one per byte left in the window, up to MAX_TOKEN_LEN) and through
// the trailing string run and the end token. A decision that yields two
// tokens fills the queue faster than rsp empties it, so a drain with several
// such decisions waits for queue room, and a stalled rsp stretches it further.
// last_of_run marks the final token caused by a beat. Configure the csr
// registers only while idle.
module keyword_table_tokenizer_unit
   import ktt_pkg::*;
#(
   parameter int NUM_TOKENS    = NUM_TOKENS_DEF,
   parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
   parameter int OFFSET_BITS   = OFFSET_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FILL_W = $clog2(MAX_TOKEN_LEN + 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MAX_TOKEN_LEN);

   // configuration
   logic [63:0] text_ff [SLOT_COUNT];
   logic [15:0] lengths_ff;
   logic [31:0] symbols_ff;
   logic [2:0]  count_ff;
   logic [15:0] special_ff;

   // stream state
   logic [7:0]             window_ff [MAX_TOKEN_LEN];
   logic [7:0]             window_in [MAX_TOKEN_LEN];
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [POS_W-1:0]       line_ff, line_in;
   logic [POS_W-1:0]       column_ff, column_in;
   logic                   run_ff, run_in;
   logic [OFFSET_BITS-1:0] run_offset_ff, run_offset_in;
   logic [POS_W-1:0]       run_line_ff, run_line_in;
   logic [POS_W-1:0]       run_column_ff, run_column_in;
   logic                   drain_ff, drain_in;

   // result queue
   rsp_type                fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, wr_ptr_ff;
   logic [FIFO_CNT_W-1:0]  qcount_ff;

   logic                   accept, append, pop;
   logic [7:0]             win_app [MAX_TOKEN_LEN];
   logic [FILL_W-1:0]      fill_app;
   logic [7:0]             dw [MAX_TOKEN_LEN];
   logic [FILL_W-1:0]      df;
   logic                   do_decide, do_final;
   logic [2:0]             slot_limit;
   logic                   hit;
   logic [3:0]             hit_len;
   logic [7:0]             hit_sym;
   logic [SLOT_COUNT-1:0]  slot_ok;
   logic                   blank;
   logic [FILL_W-1:0]      drop;
   rsp_type                res_a, res_b;
   logic                   res_a_v, res_b_v;
   rsp_type                push0, push1;
   logic [1:0]             push_cnt;

   assign accept    = req_valid && !req_stall;
   assign req_stall = drain_ff || (qcount_ff > FIFO_CNT_W'(2));
   assign append    = accept && req_data.has_byte && (fill_ff < FILL_FULL);
   assign fill_app  = fill_ff + FILL_W'(append);

   always_comb begin
      for (int i = 0; i < MAX_TOKEN_LEN; i++) begin
         win_app[i] = (append && fill_ff == FILL_W'(i)) ? req_data.byte_value : window_ff[i];
      end
   end

   // drain works from the stored window; normal beats from the appended one
   always_comb begin
      for (int i = 0; i < MAX_TOKEN_LEN; i++) begin
         dw[i] = drain_ff ? window_ff[i] : win_app[i];
      end
      df = drain_ff ? fill_ff : fill_app;
   end

   assign do_decide = drain_ff ? ((fill_ff != '0) && (qcount_ff <= FIFO_CNT_W'(2)))
                               : (accept && !req_data.end_of_text && (fill_app >= FILL_FULL));
   assign do_final  = drain_ff && (fill_ff == '0) && (qcount_ff <= FIFO_CNT_W'(2));

   assign slot_limit = (count_ff > 3'(NUM_TOKENS)) ? 3'(NUM_TOKENS) : count_ff;
   assign blank      = is_blank(dw[0]);

   // parallel slot compare; lowest slot wins
   always_comb begin
      hit     = 1'b0;
      hit_len = '0;
      hit_sym = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         slot_ok[s] = (s < NUM_TOKENS) && (3'(s) < slot_limit)
                   && (lengths_ff[4*s +: 4] != 4'd0)
                   && ({1'b0, lengths_ff[4*s +: 4]} <= 5'(MAX_TOKEN_LEN))
                   && ({1'b0, lengths_ff[4*s +: 4]} <= 5'(df));
         for (int j = 0; j < MAX_TOKEN_LEN; j++) begin
            if ((4'(j) < lengths_ff[4*s +: 4]) && (text_ff[s][8*j +: 8] != dw[j])) begin
               slot_ok[s] = 1'b0;
            end
         end
      end
      for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
         if (slot_ok[s]) begin
            hit     = 1'b1;
            hit_len = lengths_ff[4*s +: 4];
            hit_sym = symbols_ff[8*s +: 8];
         end
      end
   end

   // decision and next state
   always_comb begin
      fill_in       = drain_ff ? fill_ff : fill_app;
      offset_in     = offset_ff;
      line_in       = line_ff;
      column_in     = column_ff;
      run_in        = run_ff;
      run_offset_in = run_offset_ff;
      run_line_in   = run_line_ff;
      run_column_in = run_column_ff;
      drain_in      = drain_ff || (accept && req_data.end_of_text);
      drop          = '0;

      res_a_v = 1'b0;
      res_b_v = 1'b0;
      // pending string run
      res_a.token_start  = FIELD_W'(run_offset_ff);
      res_a.token_length = FIELD_W'(offset_ff - run_offset_ff);
      res_a.token_line   = run_line_ff;
      res_a.token_column = run_column_ff;
      res_a.token_symbol = special_ff[7:0];
      // keyword or end token
      res_b.token_start  = FIELD_W'(offset_ff);
      res_b.token_length = do_final ? '0 : FIELD_W'(hit_len);
      res_b.token_line   = line_ff;
      res_b.token_column = column_ff;
      res_b.token_symbol = do_final ? special_ff[15:8] : hit_sym;

      if (do_decide) begin
         if (blank) begin
            res_a_v = run_ff;
            run_in  = 1'b0;
            if (dw[0] == CHAR_NL) begin
               line_in   = sat_add16(line_ff, 5'd1);
               column_in = POS_W'(1);
            end else begin
               column_in = sat_add16(column_ff, (dw[0] == CHAR_TAB) ? TAB_ADVANCE : 5'd1);
            end
            drop = FILL_W'(1);
         end else if (hit) begin
            res_a_v   = run_ff;
            res_b_v   = 1'b1;
            run_in    = 1'b0;
            column_in = sat_add16(column_ff, {1'b0, hit_len});
            drop      = FILL_W'(hit_len);
         end else begin
            if (!run_ff) begin
               run_offset_in = offset_ff;
               run_line_in   = line_ff;
               run_column_in = column_ff;
            end
            run_in    = 1'b1;
            column_in = sat_add16(column_ff, 5'd1);
            drop      = FILL_W'(1);
         end
         fill_in   = df - drop;
         offset_in = offset_ff + OFFSET_BITS'(drop);
      end

      for (int i = 0; i < MAX_TOKEN_LEN; i++) begin
         window_in[i] = (drop == '0) ? dw[i] : 8'd0;
         for (int k = 1; k <= MAX_TOKEN_LEN; k++) begin
            if (drop == FILL_W'(k) && (i + k < MAX_TOKEN_LEN)) begin
               window_in[i] = dw[i+k];
            end
         end
      end

      if (do_final) begin
         res_a_v       = run_ff;
         res_b_v       = 1'b1;
         drain_in      = 1'b0;
         fill_in       = '0;
         offset_in     = '0;
         line_in       = POS_W'(1);
         column_in     = '0;
         run_in        = 1'b0;
         run_offset_in = '0;
         run_line_in   = POS_W'(1);
         run_column_in = '0;
         for (int i = 0; i < MAX_TOKEN_LEN; i++) begin
            window_in[i] = 8'd0;
         end
      end

      // last token of a beat: drain decisions never end the beat
      res_a.last_of_run = !drain_ff && !res_b_v;
      res_b.last_of_run = !drain_ff || do_final;
   end

   // compact the two result slots into queue writes
   always_comb begin
      push0    = res_a;
      push1    = res_b;
      push_cnt = 2'(res_a_v) + 2'(res_b_v);
      if (!res_a_v) begin
         push0 = res_b;
      end
   end

   assign rsp_valid = (qcount_ff != '0);
   assign rsp_data  = fifo_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      for (int e = 0; e < FIFO_DEPTH; e++) begin
         if (push_cnt != 2'd0 && wr_ptr_ff == FIFO_PTR_W'(e)) begin
            fifo_ff[e] <= push0;
         end
         if (push_cnt == 2'd2 && FIFO_PTR_W'(wr_ptr_ff + 1'b1) == FIFO_PTR_W'(e)) begin
            fifo_ff[e] <= push1;
         end
      end
      if (reset) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            text_ff[s] <= '0;
         end
         lengths_ff    <= '0;
         symbols_ff    <= '0;
         count_ff      <= '0;
         special_ff    <= '0;
         fill_ff       <= '0;
         offset_ff     <= '0;
         line_ff       <= POS_W'(1);
         column_ff     <= '0;
         run_ff        <= 1'b0;
         run_offset_ff <= '0;
         run_line_ff   <= POS_W'(1);
         run_column_ff <= '0;
         drain_ff      <= 1'b0;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         qcount_ff     <= '0;
         for (int i = 0; i < MAX_TOKEN_LEN; i++) begin
            window_ff[i] <= 8'd0;
         end
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_TEXT0:   text_ff[0] <= csr_wdata;
               CSR_TEXT1:   text_ff[1] <= csr_wdata;
               CSR_TEXT2:   text_ff[2] <= csr_wdata;
               CSR_TEXT3:   text_ff[3] <= csr_wdata;
               CSR_LENGTHS: lengths_ff <= csr_wdata[15:0];
               CSR_SYMBOLS: symbols_ff <= csr_wdata[31:0];
               CSR_COUNT:   count_ff   <= csr_wdata[2:0];
               CSR_SPECIAL: special_ff <= csr_wdata[15:0];
               default:     ;
            endcase
         end
         for (int i = 0; i < MAX_TOKEN_LEN; i++) begin
            window_ff[i] <= window_in[i];
         end
         fill_ff       <= fill_in;
         offset_ff     <= offset_in;
         line_ff       <= line_in;
         column_ff     <= column_in;
         run_ff        <= run_in;
         run_offset_ff <= run_offset_in;
         run_line_ff   <= run_line_in;
         run_column_ff <= run_column_in;
         drain_ff      <= drain_in;
         wr_ptr_ff     <= wr_ptr_ff + FIFO_PTR_W'(push_cnt);
         rd_ptr_ff     <= rd_ptr_ff + FIFO_PTR_W'(pop);
         qcount_ff     <= qcount_ff + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
      end
   end

endmodule
`default_nettype wire

### rtl/core/ktt_checker.sv
// Port-level checks for the keyword table tokenizer, bound to the top level.
`default_nettype none
module ktt_port_checker
   import ktt_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp beat right after reset");

   // a stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");

   // line counting starts at 1 and saturates, never 0
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.token_line != '0)
      else $error("token_line is zero");

   // end of text starts a drain that holds off the next req beat
   a_eot_drain: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.end_of_text |=> req_stall)
      else $error("req taken right after end of text");

endmodule

bind keyword_table_tokenizer_unit ktt_port_checker u_ktt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
